// ===== hdl/pliu_pkg.sv =====
// Package with the request kinds, status codes and sequencer states of the list unit.
package pliu_pkg;

    typedef enum logic [2:0] {
        KIND_SET_LENGTH = 3'd0,
        KIND_READ       = 3'd1,
        KIND_INSERT     = 3'd2,
        KIND_UPDATE     = 3'd3,
        KIND_DELETE     = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_FULL    = 3'd1,
        STATUS_EMPTY   = 3'd2,
        STATUS_BAD_POS = 3'd3,
        STATUS_BAD_LEN = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_FINISH
    } t_state;

endpackage

// ===== hdl/positional_list_insert_delete_unit.sv =====
// Top level of the positional list unit: sequencer, list memory and result register.
//
// This unit keeps an ordered list of up to CAPACITY signed 32-bit words and
// its current length, and answers one transaction at a time. Each accepted
// input transaction (set length, read, insert, update or delete at a
// position) gives exactly one result transaction with a status, the word
// read (zero unless a read succeeded) and the length after the request.
// The words live in a single-port-style memory with one write and one
// registered read per cycle, and a small sequencer moves the list through
// it one word at a time: each moved word is read in one state and written
// in the next. A set length, an update or any rejected request goes
// straight to the finish state, a read passes through the read state
// first, and an insert or a delete moves the later words up or down one
// place before it finishes. The input stays stalled from acceptance until
// the result is loaded into the output register; a result that waits
// there does not keep the next transaction out, but that transaction
// cannot finish until the waiting result is taken. Words exposed by
// raising the length hold no defined value until they are written. No
// clearing pass runs after reset, so requests are taken once it is released.
module positional_list_insert_delete_unit #(
    parameter int CAPACITY = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_kind,
    input  logic [7:0]         i_position,
    input  logic signed [31:0] i_item_value,
    input  logic [7:0]         i_requested_length,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_read_value,
    output logic [7:0]         o_length_now
);

    // Count needs to hold CAPACITY itself; an index only needs CAPACITY-1.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    // Comparison width that holds both an 8-bit position and the count.
    localparam int KW = (CW > 8) ? CW : 8;

    // The list storage. Entries are written at one address and read at one
    // address per cycle, with the read data registered.
    logic [31:0] mem [CAPACITY];

    pliu_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_pos, n_pos;
    logic [31:0]       r_val, n_val;
    pliu_pkg::t_status r_status, n_status;
    logic              r_read_ok, n_read_ok;
    logic [31:0]       r_mem_rdata;

    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_status, n_out_status;
    logic [31:0]       r_out_read, n_out_read;
    logic [7:0]        r_out_length, n_out_length;

    // Memory port controls driven by the sequencer.
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [31:0]       mem_wd;
    logic              mem_re;
    logic [AW-1:0]     mem_ra;

    logic [KW-1:0]     pos_k;
    logic [KW-1:0]     cnt_k;
    logic [KW-1:0]     req_k;

    assign pos_k = KW'(i_position);
    assign cnt_k = KW'(r_count);
    assign req_k = KW'(i_requested_length);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_rdata <= mem[mem_ra];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pliu_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_status     <= n_status;
        r_read_ok    <= n_read_ok;
        r_out_status <= n_out_status;
        r_out_read   <= n_out_read;
        r_out_length <= n_out_length;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_val        = r_val;
        n_status     = r_status;
        n_read_ok    = r_read_ok;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_read   = r_out_read;
        n_out_length = r_out_length;
        mem_we       = 1'b0;
        mem_wa       = r_idx;
        mem_wd       = r_mem_rdata;
        mem_re       = 1'b0;
        mem_ra       = r_idx;

        // A waiting result leaves once the consumer takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pliu_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    // Every request goes through the finish state; the checks
                    // below only choose the status and any work in between.
                    n_state   = pliu_pkg::S_FINISH;
                    n_status  = pliu_pkg::STATUS_OK;
                    n_read_ok = 1'b0;
                    n_val     = i_item_value;
                    n_pos     = AW'(i_position);
                    case (pliu_pkg::t_kind'(i_kind))
                        pliu_pkg::KIND_SET_LENGTH: begin
                            if (req_k > KW'(CAPACITY)) begin
                                n_status = pliu_pkg::STATUS_BAD_LEN;
                            end else begin
                                n_count = CW'(i_requested_length);
                            end
                        end
                        pliu_pkg::KIND_READ: begin
                            if (r_count == '0) begin
                                n_status = pliu_pkg::STATUS_EMPTY;
                            end else if (pos_k >= cnt_k) begin
                                n_status = pliu_pkg::STATUS_BAD_POS;
                            end else begin
                                n_idx     = AW'(i_position);
                                n_read_ok = 1'b1;
                                n_state   = pliu_pkg::S_READ;
                            end
                        end
                        pliu_pkg::KIND_INSERT: begin
                            if (cnt_k >= KW'(CAPACITY)) begin
                                n_status = pliu_pkg::STATUS_FULL;
                            end else if (pos_k > cnt_k) begin
                                n_status = pliu_pkg::STATUS_BAD_POS;
                            end else begin
                                // Shifting starts at the top free slot.
                                n_idx   = AW'(r_count);
                                n_state = pliu_pkg::S_INS_RD;
                            end
                        end
                        pliu_pkg::KIND_UPDATE: begin
                            if (r_count == '0) begin
                                n_status = pliu_pkg::STATUS_EMPTY;
                            end else if (pos_k >= cnt_k) begin
                                n_status = pliu_pkg::STATUS_BAD_POS;
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = AW'(i_position);
                                mem_wd = i_item_value;
                            end
                        end
                        pliu_pkg::KIND_DELETE: begin
                            if (r_count == '0) begin
                                n_status = pliu_pkg::STATUS_EMPTY;
                            end else if (pos_k >= cnt_k) begin
                                n_status = pliu_pkg::STATUS_BAD_POS;
                            end else begin
                                n_idx   = AW'(i_position);
                                n_state = pliu_pkg::S_DEL_RD;
                            end
                        end
                        default: begin
                            // Unknown kinds change nothing and report ok.
                        end
                    endcase
                end
            end
            pliu_pkg::S_READ: begin
                mem_re  = 1'b1;
                n_state = pliu_pkg::S_FINISH;
            end
            pliu_pkg::S_INS_RD: begin
                if (r_idx == r_pos) begin
                    // All later words have moved up; drop the new word in.
                    mem_we  = 1'b1;
                    mem_wa  = r_idx;
                    mem_wd  = r_val;
                    n_count = r_count + CW'(1);
                    n_state = pliu_pkg::S_FINISH;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = r_idx - AW'(1);
                    n_state = pliu_pkg::S_INS_WR;
                end
            end
            pliu_pkg::S_INS_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx;
                mem_wd  = r_mem_rdata;
                n_idx   = r_idx - AW'(1);
                n_state = pliu_pkg::S_INS_RD;
            end
            pliu_pkg::S_DEL_RD: begin
                if (CW'(r_idx) + CW'(1) == r_count) begin
                    // The last word has moved down; the top slot is dropped.
                    n_count = r_count - CW'(1);
                    n_state = pliu_pkg::S_FINISH;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = r_idx + AW'(1);
                    n_state = pliu_pkg::S_DEL_WR;
                end
            end
            pliu_pkg::S_DEL_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx;
                mem_wd  = r_mem_rdata;
                n_idx   = r_idx + AW'(1);
                n_state = pliu_pkg::S_DEL_RD;
            end
            pliu_pkg::S_FINISH: begin
                // Wait here until the output register is free or being emptied.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_read   = r_read_ok ? r_mem_rdata : 32'd0;
                    n_out_length = 8'(r_count);
                    n_state      = pliu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pliu_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall   = (r_state != pliu_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_value = r_out_read;
    assign o_length_now = r_out_length;

endmodule

// ===== hdl/pliu_checker.sv =====
// Port-level checker for the positional list unit and its bind statement.
module pliu_checker #(
    parameter int CAPACITY = 128
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_status,
    input logic signed [31:0] o_read_value,
    input logic [7:0]         o_length_now
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_read_value) && $stable(o_length_now))
        else $error("result changed while stalled");

    // Only one transaction is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted again without working the previous one");

    // A nonzero word can only come from a successful read.
    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_value != 32'sd0 |-> o_status == pliu_pkg::STATUS_OK)
        else $error("word returned with a failing status");

    // The reported length never exceeds the capacity.
    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAPACITY > 255) || (32'(o_length_now) <= 32'(CAPACITY)))
        else $error("length above capacity");

endmodule

bind positional_list_insert_delete_unit pliu_checker #(
    .CAPACITY(CAPACITY)
) u_pliu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_read_value (o_read_value),
    .o_length_now (o_length_now)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the positional list unit: directed table, random traffic, scoreboard.
module tb;

    localparam int LIST_CAPACITY = 128;
    // Kinds the unit has no operation for; they must leave the list alone.
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
    localparam int RESET_CYCLES     = 10;
    localparam int ITEMS_PER_PHASE  = 310;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int DRAIN_CYCLES     = 20;
    // Worst correct gap between two accepted transactions is a full-length
    // insert behind the long receiver hold-off, so this leaves a wide margin.
    localparam int QUIET_LIMIT      = 5000;

    typedef struct {
        logic [2:0]         kind;
        logic [7:0]         pos;
        logic signed [31:0] value;
        logic [7:0]         req_len;
    } t_request;

    typedef struct {
        pliu_pkg::t_status  status;
        logic signed [31:0] read_value;
        logic [7:0]         length_now;
    } t_reply;

    // One row of the directed table. When fixed is set, the reply typed in
    // the row is what the unit must return; otherwise the predictor decides.
    typedef struct {
        logic [2:0]         kind;
        logic [7:0]         pos;
        logic signed [31:0] value;
        logic [7:0]         req_len;
        bit                 fixed;
        pliu_pkg::t_status  status;
        logic signed [31:0] read_value;
        logic [7:0]         length_now;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_kind = 3'd0;
    logic [7:0]         i_position = 8'd0;
    logic signed [31:0] i_item_value = 32'sd0;
    logic [7:0]         i_requested_length = 8'd0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [2:0]         o_status;
    logic signed [31:0] o_read_value;
    logic [7:0]         o_length_now;

    positional_list_insert_delete_unit #(
        .CAPACITY(LIST_CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_position(i_position),
        .i_item_value(i_item_value),
        .i_requested_length(i_requested_length),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status(o_status),
        .o_read_value(o_read_value),
        .o_length_now(o_length_now)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predicted list contents. word_written tracks which slots hold a value
    // written since reset, so that a read of an undefined word is never sent.
    logic signed [31:0] list_words [LIST_CAPACITY];
    bit                 word_written [LIST_CAPACITY];
    int                 list_len;
    bit                 growing;

    t_reply pending_replies [$];
    int     mismatch_count;
    int     snd_idle_pct;
    int     rcv_idle_pct;
    int     hold_request;
    int     hold_left;

    // Applies one request to the predicted list and returns the reply it gives.
    function automatic t_reply list_apply(t_request rq);
        t_reply rp;
        int     p;
        int     i;
        p = rq.pos;
        rp.status = pliu_pkg::STATUS_OK;
        rp.read_value = 32'sd0;
        case (rq.kind)
            pliu_pkg::KIND_SET_LENGTH: begin
                if (rq.req_len > LIST_CAPACITY) rp.status = pliu_pkg::STATUS_BAD_LEN;
                else list_len = rq.req_len;
            end
            pliu_pkg::KIND_READ: begin
                if (list_len == 0) rp.status = pliu_pkg::STATUS_EMPTY;
                else if (p >= list_len) rp.status = pliu_pkg::STATUS_BAD_POS;
                else rp.read_value = list_words[p];
            end
            pliu_pkg::KIND_INSERT: begin
                if (list_len >= LIST_CAPACITY) begin
                    rp.status = pliu_pkg::STATUS_FULL;
                end else if (p > list_len) begin
                    rp.status = pliu_pkg::STATUS_BAD_POS;
                end else begin
                    for (i = list_len; i > p; i--) begin
                        list_words[i] = list_words[i - 1];
                        word_written[i] = word_written[i - 1];
                    end
                    list_words[p] = rq.value;
                    word_written[p] = 1'b1;
                    list_len++;
                end
            end
            pliu_pkg::KIND_UPDATE: begin
                if (list_len == 0) begin
                    rp.status = pliu_pkg::STATUS_EMPTY;
                end else if (p >= list_len) begin
                    rp.status = pliu_pkg::STATUS_BAD_POS;
                end else begin
                    list_words[p] = rq.value;
                    word_written[p] = 1'b1;
                end
            end
            pliu_pkg::KIND_DELETE: begin
                if (list_len == 0) begin
                    rp.status = pliu_pkg::STATUS_EMPTY;
                end else if (p >= list_len) begin
                    rp.status = pliu_pkg::STATUS_BAD_POS;
                end else begin
                    // The last slot keeps its old word, as the shift only
                    // copies downward.
                    for (i = p; i + 1 < list_len; i++) begin
                        list_words[i] = list_words[i + 1];
                        word_written[i] = word_written[i + 1];
                    end
                    list_len--;
                end
            end
            default: ;
        endcase
        rp.length_now = 8'(list_len);
        return rp;
    endfunction

    // Draws the next random request. Most requests are legal list operations
    // that follow a slow grow or shrink trend, so the list walks between empty
    // and full; the rest are length changes, spare kinds and random noise.
    function automatic t_request next_list_request();
        t_request rq;
        int       roll;
        int       choice;
        int       top;
        if (growing && list_len == LIST_CAPACITY && $urandom_range(9) == 0) growing = 1'b0;
        else if (!growing && list_len == 0 && $urandom_range(9) == 0) growing = 1'b1;
        else if ($urandom_range(199) == 0) growing = !growing;

        rq.kind = pliu_pkg::KIND_READ;
        rq.pos = 8'd0;
        rq.value = $urandom;
        rq.req_len = 8'($urandom_range(255, 0));
        if ($urandom_range(15) == 0) begin
            case ($urandom_range(3))
                0: rq.value = 32'sh8000_0000;
                1: rq.value = 32'sh7FFF_FFFF;
                2: rq.value = -32'sd1;
                default: rq.value = 32'sd0;
            endcase
        end

        roll = $urandom_range(99);
        if (roll < 5) begin
            rq.kind = pliu_pkg::KIND_SET_LENGTH;
            case ($urandom_range(3))
                0: rq.req_len = 8'(LIST_CAPACITY);
                1: rq.req_len = 8'($urandom_range(255, LIST_CAPACITY + 1));
                2: rq.req_len = 8'd0;
                default: begin
                    top = (list_len + 6 > LIST_CAPACITY) ? LIST_CAPACITY : list_len + 6;
                    rq.req_len = 8'($urandom_range(top, 0));
                end
            endcase
        end else if (roll < 7) begin
            rq.kind = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
            rq.pos = 8'($urandom_range(255, 0));
        end else if (roll < 13) begin
            rq.kind = 3'($urandom_range(pliu_pkg::KIND_DELETE, pliu_pkg::KIND_SET_LENGTH));
            rq.pos = 8'($urandom_range(255, 0));
        end else begin
            choice = $urandom_range(99);
            if (growing) begin
                if (choice < 50) rq.kind = pliu_pkg::KIND_INSERT;
                else if (choice < 70) rq.kind = pliu_pkg::KIND_READ;
                else if (choice < 85) rq.kind = pliu_pkg::KIND_UPDATE;
                else rq.kind = pliu_pkg::KIND_DELETE;
            end else begin
                if (choice < 50) rq.kind = pliu_pkg::KIND_DELETE;
                else if (choice < 65) rq.kind = pliu_pkg::KIND_INSERT;
                else if (choice < 85) rq.kind = pliu_pkg::KIND_READ;
                else rq.kind = pliu_pkg::KIND_UPDATE;
            end
            if (rq.kind == pliu_pkg::KIND_INSERT) top = list_len;
            else top = (list_len > 0) ? list_len - 1 : 0;
            // Now and then step just past the last legal position.
            if ($urandom_range(24) == 0) top = (top + 1 > 255) ? 255 : top + 1;
            else top = $urandom_range(top, 0);
            rq.pos = 8'(top);
        end

        // A read of a word that was never written has no defined answer;
        // turn it into an update, which defines the word instead.
        if (rq.kind == pliu_pkg::KIND_READ && rq.pos < list_len && !word_written[rq.pos])
            rq.kind = pliu_pkg::KIND_UPDATE;
        return rq;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offers one input transaction, waits until the unit takes it, and queues
    // the reply it must produce.
    task automatic offer(input t_request rq, input bit fixed, input t_reply fixed_reply);
        t_reply predicted;
        if ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_kind <= rq.kind;
        i_position <= rq.pos;
        i_item_value <= rq.value;
        i_requested_length <= rq.req_len;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = list_apply(rq);
        pending_replies.push_back(fixed ? fixed_reply : predicted);
    endtask

    // Receiver side: random stall, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // Scoreboard: every result transaction is matched to the oldest reply.
    always @(posedge i_clk) begin : result_check
        t_reply want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_replies.size() == 0) begin
                note_mismatch("result with none outstanding, status", 32'(o_status), 32'd0);
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status)
                    note_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_read_value !== want.read_value)
                    note_mismatch("read_value", o_read_value, want.read_value);
                if (o_length_now !== want.length_now)
                    note_mismatch("length_now", 32'(o_length_now), 32'(want.length_now));
            end
        end
    end

    // Ends the run if no transaction moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        t_plan_row plan [25];
        t_request  rq;
        t_reply    rp;
        int        phase;
        int        n;
        int        snd_by_phase [3];
        int        rcv_by_phase [3];

        // The table starts from an empty list, probes the empty and length
        // errors, builds a three-word list with the extreme values and probes
        // it, then jumps to a full list to see an insert refused as full.
        plan = '{
            '{pliu_pkg::KIND_READ,        8'd0,   32'sd0,           8'd0,   1'b1,
              pliu_pkg::STATUS_EMPTY,   32'sd0,           8'd0},
            '{pliu_pkg::KIND_UPDATE,      8'd5,   32'sd7,           8'd0,   1'b1,
              pliu_pkg::STATUS_EMPTY,   32'sd0,           8'd0},
            '{pliu_pkg::KIND_DELETE,      8'd0,   32'sd0,           8'd0,   1'b1,
              pliu_pkg::STATUS_EMPTY,   32'sd0,           8'd0},
            '{pliu_pkg::KIND_SET_LENGTH,  8'd0,   32'sd0,           8'd129, 1'b1,
              pliu_pkg::STATUS_BAD_LEN, 32'sd0,           8'd0},
            '{pliu_pkg::KIND_SET_LENGTH,  8'd0,   32'sd0,           8'd255, 1'b1,
              pliu_pkg::STATUS_BAD_LEN, 32'sd0,           8'd0},
            '{pliu_pkg::KIND_INSERT,      8'd1,   32'sd5,           8'd0,   1'b1,
              pliu_pkg::STATUS_BAD_POS, 32'sd0,           8'd0},
            '{pliu_pkg::KIND_INSERT,      8'd0,   32'sh8000_0000,   8'd0,   1'b1,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd1},
            '{pliu_pkg::KIND_INSERT,      8'd1,   32'sh7FFF_FFFF,   8'd0,   1'b1,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd2},
            '{pliu_pkg::KIND_INSERT,      8'd0,   -32'sd1,          8'd0,   1'b1,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd3},
            '{pliu_pkg::KIND_READ,        8'd0,   32'sd0,           8'd0,   1'b1,
              pliu_pkg::STATUS_OK,      -32'sd1,          8'd3},
            '{pliu_pkg::KIND_READ,        8'd2,   32'sd0,           8'd0,   1'b1,
              pliu_pkg::STATUS_OK,      32'sh7FFF_FFFF,   8'd3},
            '{pliu_pkg::KIND_READ,        8'd3,   32'sd0,           8'd0,   1'b1,
              pliu_pkg::STATUS_BAD_POS, 32'sd0,           8'd3},
            '{pliu_pkg::KIND_UPDATE,      8'd1,   32'sh5555_5555,   8'd0,   1'b1,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd3},
            '{pliu_pkg::KIND_UPDATE,      8'd255, 32'sd1,           8'd0,   1'b1,
              pliu_pkg::STATUS_BAD_POS, 32'sd0,           8'd3},
            '{pliu_pkg::KIND_DELETE,      8'd0,   32'sd0,           8'd0,   1'b1,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd2},
            '{pliu_pkg::KIND_READ,        8'd0,   32'sd0,           8'd0,   1'b0,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd0},
            '{pliu_pkg::KIND_DELETE,      8'd2,   32'sd0,           8'd0,   1'b1,
              pliu_pkg::STATUS_BAD_POS, 32'sd0,           8'd2},
            '{KIND_SPARE_FIRST,           8'd255, -32'sd1,          8'd255, 1'b1,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd2},
            '{KIND_SPARE_LAST,            8'd0,   32'sd0,           8'd0,   1'b1,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd2},
            '{pliu_pkg::KIND_SET_LENGTH,  8'd0,   32'sd0,           8'd128, 1'b1,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd128},
            '{pliu_pkg::KIND_INSERT,      8'd0,   32'sd3,           8'd0,   1'b1,
              pliu_pkg::STATUS_FULL,    32'sd0,           8'd128},
            '{pliu_pkg::KIND_UPDATE,      8'd127, 32'shAAAA_AAAA,   8'd0,   1'b0,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd0},
            '{pliu_pkg::KIND_READ,        8'd127, 32'sd0,           8'd0,   1'b0,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd0},
            '{pliu_pkg::KIND_DELETE,      8'd127, 32'sd0,           8'd0,   1'b0,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd0},
            '{pliu_pkg::KIND_SET_LENGTH,  8'd0,   32'sd0,           8'd0,   1'b1,
              pliu_pkg::STATUS_OK,      32'sd0,           8'd0}
        };
        snd_by_phase = '{8, 88, 0};
        rcv_by_phase = '{88, 8, 0};

        list_len = 0;
        growing = 1'b1;
        mismatch_count = 0;
        hold_request = 0;
        hold_left = 0;
        for (n = 0; n < LIST_CAPACITY; n++) begin
            list_words[n] = 32'sd0;
            word_written[n] = 1'b0;
        end
        snd_idle_pct = snd_by_phase[0];
        rcv_idle_pct = rcv_by_phase[0];

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            rq.kind = plan[r].kind;
            rq.pos = plan[r].pos;
            rq.value = plan[r].value;
            rq.req_len = plan[r].req_len;
            rp.status = plan[r].status;
            rp.read_value = plan[r].read_value;
            rp.length_now = plan[r].length_now;
            offer(rq, plan[r].fixed, rp);
        end

        for (phase = 0; phase < 3; phase++) begin
            snd_idle_pct = snd_by_phase[phase];
            rcv_idle_pct = rcv_by_phase[phase];
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Sender pause: let every outstanding result drain first.
                if (phase == 0 && n == 150) begin
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (pending_replies.size() != 0);
                end
                // Receiver hold-off while the sender keeps offering, so the
                // output register fills and the unit stalls its input.
                if (phase == 2 && n == 100) hold_request = HOLD_OFF_CYCLES;
                rq = next_list_request();
                offer(rq, 1'b0, rp);
            end
        end
        i_in_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== positional_list_insert_delete_unit.f =====
hdl/pliu_pkg.sv
hdl/positional_list_insert_delete_unit.sv
hdl/pliu_checker.sv
verif/tb.sv
